// File: design/ccr_pkg.sv
// Shared constants and input codes for the concentric circle rasterizer.
package ccr_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int RAD_BITS       = 11;
    localparam int DEC_BITS       = 13;
    localparam int COLOR_BITS     = 24;
    // Working width for decision updates: holds d +/- 2*offset without overflow.
    localparam int CALC_BITS      = 15;

    typedef enum logic {
        MODE_START   = 1'b0,
        MODE_ADVANCE = 1'b1
    } t_mode;

endpackage

// File: design/concentric_circle_rasterizer_unit.sv
// Concentric circle rasterizer: Andres circle stepper with an eight-pixel emitter.
// An advance item presents its first pixel in the cycle after acceptance.
// Advance items are paced by the single result channel, which carries the eight
//   symmetric pixels one per cycle while i_m_tready is high; a new item is accepted as the last pixel leaves.
// Reset (i_rst_n low, synchronous): drawing idle, emitter empty, no output valid.
module concentric_circle_rasterizer_unit #(
    parameter int COORD_BITS = ccr_pkg::COORD_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // Slave side: input items
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // tdata: center_x[COORD_BITS], center_y[COORD_BITS], radius[11], rings[11],
    //        color[24], zero pad to whole bytes
    input  logic [((2*COORD_BITS + 2*ccr_pkg::RAD_BITS + ccr_pkg::COLOR_BITS + 7)/8)*8-1:0]
                 i_s_tdata,
    // tuser: mode (0 start, 1 advance)
    input  logic i_s_tuser,
    // Master side: pixels
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // tdata: pixel_x[COORD_BITS+2], pixel_y[COORD_BITS+2], pixel_color[24],
    //        zero pad to whole bytes
    output logic [((2*(COORD_BITS+2) + ccr_pkg::COLOR_BITS + 7)/8)*8-1:0]
                 o_m_tdata,
    // tlast: step_last (eighth pixel of one iteration)
    output logic o_m_tlast,
    // tuser: drawing_done (final pixel of the whole drawing)
    output logic o_m_tuser
);
    import ccr_pkg::*;

    localparam int CW      = COORD_BITS + 2;
    localparam int IN_W    = 2*COORD_BITS + 2*RAD_BITS + COLOR_BITS;
    localparam int OUT_W   = 2*CW + COLOR_BITS;
    localparam int OUT_PADW = ((OUT_W + 7)/8)*8;

    // Input field unpack
    logic [COORD_BITS-1:0] in_cx, in_cy;
    logic [RAD_BITS-1:0]   in_radius, in_rings;
    logic [COLOR_BITS-1:0] in_color;
    t_mode                 in_mode;

    assign in_cx     = i_s_tdata[COORD_BITS-1:0];
    assign in_cy     = i_s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_radius = i_s_tdata[2*COORD_BITS+RAD_BITS-1:2*COORD_BITS];
    assign in_rings  = i_s_tdata[2*COORD_BITS+2*RAD_BITS-1:2*COORD_BITS+RAD_BITS];
    assign in_color  = i_s_tdata[IN_W-1:2*COORD_BITS+2*RAD_BITS];
    assign in_mode   = t_mode'(i_s_tuser);

    // Drawing state
    logic                  r_busy;
    logic [COORD_BITS-1:0] r_ctr_x, r_ctr_y;
    logic [COLOR_BITS-1:0] r_pix_color;
    logic [RAD_BITS-1:0]   r_cur_radius, r_rings_left, r_off_x, r_off_y;
    logic [DEC_BITS-1:0]   r_decision;

    // Emitter buffer: one iteration's eight pixels, served one per cycle while i_m_tready is high
    logic                  r_b_valid;
    logic [2:0]            r_k;
    logic [COORD_BITS-1:0] r_b_cx, r_b_cy;
    logic [RAD_BITS-1:0]   r_b_x, r_b_y;
    logic [COLOR_BITS-1:0] r_b_color;
    logic                  r_b_done;

    logic out_fire, out_last, in_fire, adv_fire;

    assign out_fire   = r_b_valid & i_m_tready;
    assign out_last   = (r_k == 3'(7));
    // A new item may enter while the last pixel of the previous one leaves.
    assign o_s_tready = ~r_b_valid | (out_fire & out_last);
    assign in_fire    = i_s_tvalid & o_s_tready;
    assign adv_fire   = in_fire & (in_mode == MODE_ADVANCE) & r_busy;

    // One Andres iteration on the current octant point
    logic signed [CALC_BITS-1:0] d_w, x_w, y_w, r_w, nd_w, nx_w, ny_w;
    logic                        step_cont, ring_next;

    always_comb begin
        d_w = CALC_BITS'(signed'(r_decision));
        x_w = signed'(CALC_BITS'(r_off_x));
        y_w = signed'(CALC_BITS'(r_off_y));
        r_w = signed'(CALC_BITS'(r_cur_radius));
        if (d_w >= (x_w <<< 1)) begin
            nd_w = d_w - (x_w <<< 1) - CALC_BITS'(1);
            nx_w = x_w + CALC_BITS'(1);
            ny_w = y_w;
        end else if (d_w < ((r_w - y_w) <<< 1)) begin
            nd_w = d_w + (y_w <<< 1) - CALC_BITS'(1);
            nx_w = x_w;
            ny_w = y_w - CALC_BITS'(1);
        end else begin
            nd_w = d_w + ((y_w - x_w - CALC_BITS'(1)) <<< 1);
            nx_w = x_w + CALC_BITS'(1);
            ny_w = y_w - CALC_BITS'(1);
        end
        step_cont = (ny_w >= nx_w);
        ring_next = (r_cur_radius != '0) && (r_rings_left != '0);
    end

    // Drawing state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (in_fire && in_mode == MODE_START) begin
            r_busy <= 1'b1;
        end else if (adv_fire && !step_cont && !ring_next) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && in_mode == MODE_START) begin
            r_ctr_x      <= in_cx;
            r_ctr_y      <= in_cy;
            r_cur_radius <= in_radius;
            r_rings_left <= in_rings;
            r_pix_color  <= in_color;
            r_off_x      <= '0;
            r_off_y      <= in_radius;
            r_decision   <= DEC_BITS'(in_radius) - DEC_BITS'(1);
        end else if (adv_fire) begin
            if (step_cont) begin
                r_off_x    <= nx_w[RAD_BITS-1:0];
                r_off_y    <= ny_w[RAD_BITS-1:0];
                r_decision <= nd_w[DEC_BITS-1:0];
            end else if (ring_next) begin
                // Step inward to the next ring
                r_cur_radius <= r_cur_radius - RAD_BITS'(1);
                r_rings_left <= r_rings_left - RAD_BITS'(1);
                r_off_x      <= '0;
                r_off_y      <= r_cur_radius - RAD_BITS'(1);
                r_decision   <= DEC_BITS'(r_cur_radius) - DEC_BITS'(2);
            end else begin
                r_off_x    <= '0;
                r_off_y    <= '0;
                r_decision <= '0;
            end
        end
    end

    // Emitter control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_k       <= '0;
        end else if (adv_fire) begin
            r_b_valid <= 1'b1;
            r_k       <= '0;
        end else if (out_fire) begin
            if (out_last) begin
                r_b_valid <= 1'b0;
            end
            r_k <= r_k + 3'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_fire) begin
            r_b_cx    <= r_ctr_x;
            r_b_cy    <= r_ctr_y;
            r_b_x     <= r_off_x;
            r_b_y     <= r_off_y;
            r_b_color <= r_pix_color;
            r_b_done  <= ~step_cont & ~ring_next;
        end
    end

    // Pixel select: k[0] swaps the offsets, k[1] negates the column offset,
    // k[2] negates the row offset.
    logic [CW-1:0] ox, oy, px, py;

    always_comb begin
        ox = r_k[0] ? CW'(r_b_y) : CW'(r_b_x);
        oy = r_k[0] ? CW'(r_b_x) : CW'(r_b_y);
        px = r_k[1] ? (CW'(r_b_cx) - ox) : (CW'(r_b_cx) + ox);
        py = r_k[2] ? (CW'(r_b_cy) - oy) : (CW'(r_b_cy) + oy);
    end

    assign o_m_tvalid = r_b_valid;
    assign o_m_tdata  = OUT_PADW'({r_b_color, py, px});
    assign o_m_tlast  = out_last;
    assign o_m_tuser  = out_last & r_b_done;

endmodule
